>>> src/fir_pkg.sv
package fir_pkg;

  // Field widths of the stream payloads
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned TAPS_DEF = 32;

  // Meaning of the kind bit of an input transfer
  typedef enum logic {
    KIND_COEF   = 1'b0,
    KIND_SAMPLE = 1'b1
  } fir_kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_coef;   // write one coefficient slot
    logic wr_samp;   // push a sample, clear accumulator, rewind tap pointers
    logic issue;     // read one tap and start its multiply-accumulate
    logic load_out;  // copy the finished sum into the output register
  } fir_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_tap;   // tap counter sits on the final tap
    logic warm_next;  // the next sample completes the delay line
  } fir_status_t;

endpackage

>>> src/fir_if.sv
interface fir_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fir_pkg::IDX_W-1:0]    tap_index;
  logic signed [fir_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output tap_index, output value, input ready);
  modport sink   (input valid, input kind, input tap_index, input value, output ready);
endinterface

interface fir_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fir_pkg::DATA_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

>>> src/fir_ctrl.sv
module fir_ctrl
  import fir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_kind_i,
  input  logic        out_ready_i,
  input  fir_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output fir_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } fir_state_e;

  fir_state_e state_q, state_d;
  logic       drain_q, drain_d;
  logic       out_vld_q, out_vld_d;
  logic       in_xfer;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_coef  = in_xfer && (in_kind_i == KIND_COEF);
    cmd_o.wr_samp  = in_xfer && (in_kind_i == KIND_SAMPLE);
    cmd_o.issue    = (state_q == ST_RUN);
    cmd_o.load_out = (state_q == ST_FINISH) && out_free;
  end

  // Next state: drain covers the two pipeline stages behind the last read
  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.wr_samp && status_i.warm_next) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.last_tap) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      drain_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> src/fir_dp.sv
module fir_dp
  import fir_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fir_cmd_t                 cmd_i,
  input  logic [IDX_W-1:0]         tap_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output fir_status_t              status_o,
  output logic signed [DATA_W-1:0] filtered_o
);

  localparam int unsigned AW    = $clog2(TAPS);
  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam logic [AW-1:0]    LAST_A = AW'(TAPS - 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TAPS);
  localparam logic [CNT_W-1:0] WARM_C = CNT_W'(TAPS - 1);

  // Storage
  logic [DATA_W-1:0] coef_mem [TAPS];
  logic [DATA_W-1:0] samp_mem [TAPS];
  logic [TAPS-1:0]   coef_vld_q;

  logic [AW-1:0]     coef_wa;
  logic              coef_we;
  logic [AW-1:0]     wr_pos_q, rd_ptr_q, tap_q;
  logic [CNT_W-1:0]  seen_q;
  logic [DATA_W-1:0] coef_rd_q, samp_rd_q;
  logic              coef_rd_vld_q;
  logic              mul_en_q, acc_en_q;
  logic [DATA_W-1:0] coef_op;
  logic [DATA_W-1:0] prod_d, prod_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] out_q;

  // Slots beyond the table are dropped
  assign coef_wa = AW'(tap_index_i);
  assign coef_we = cmd_i.wr_coef && ({27'd0, tap_index_i} < 32'(TAPS));

  assign status_o.last_tap  = (tap_q == LAST_A);
  assign status_o.warm_next = (seen_q >= WARM_C);
  assign filtered_o         = signed'(out_q);

  // Coefficient memory, registered read
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= value_i;
    end
    coef_rd_q <= coef_mem[tap_q];
  end

  // Valid bits stand in for the cleared table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q    <= '0;
      coef_rd_vld_q <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[coef_wa] <= 1'b1;
      end
      coef_rd_vld_q <= coef_vld_q[tap_q];
    end
  end

  // Sample delay line, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_samp) begin
      samp_mem[wr_pos_q] <= value_i;
    end
    samp_rd_q <= samp_mem[rd_ptr_q];
  end

  // Pointers, tap counter and warm-up count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      rd_ptr_q <= '0;
      tap_q    <= '0;
      seen_q   <= '0;
    end else begin
      if (cmd_i.wr_samp) begin
        wr_pos_q <= (wr_pos_q == LAST_A) ? '0 : wr_pos_q + 1'b1;
        rd_ptr_q <= wr_pos_q;
        tap_q    <= '0;
        if (seen_q != FULL_C) begin
          seen_q <= seen_q + 1'b1;
        end
      end else if (cmd_i.issue) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? LAST_A : rd_ptr_q - 1'b1;
        tap_q    <= (tap_q == LAST_A) ? '0 : tap_q + 1'b1;
      end
    end
  end

  // Multiply-accumulate pipeline: read, multiply, add
  assign coef_op = coef_rd_vld_q ? coef_rd_q : '0;
  assign prod_d  = coef_op * samp_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_en_q <= 1'b0;
      acc_en_q <= 1'b0;
    end else begin
      mul_en_q <= cmd_i.issue;
      acc_en_q <= mul_en_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.wr_samp) begin
      acc_q <= '0;
    end else if (acc_en_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.load_out) begin
      out_q <= acc_q;
    end
  end

endmodule

>>> src/fir_filter_direct_form.sv
// Direct-form FIR filter, one shared multiply-accumulate stepped over the taps.
// Coefficient transfers and warm-up samples are accepted back to back while idle.
// A sample that yields a result holds the input through its transfer cycle, one
// step per tap through the single MAC, two pipeline drain steps and the load of
// the output register; the result is offered once that register is loaded.
// A result still stalled at the output stretches the load cycle until it leaves.
// Reset (rst_ni low, asynchronous) makes every coefficient read as zero and restarts warm-up.
module fir_filter_direct_form
  import fir_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fir_in_if.sink    in_i,
  fir_out_if.source out_o
);

  fir_cmd_t    cmd;
  fir_status_t status;

  fir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  fir_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .tap_index_i (in_i.tap_index),
    .value_i     (in_i.value),
    .status_o    (status),
    .filtered_o  (out_o.filtered)
  );

endmodule

>>> src/fir_checker.sv
module fir_checker
  import fir_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] out_filtered_i
);

  // A result held back must stay offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_filtered_i))
    else $error("result changed while stalled");

  // A coefficient transfer never starts a computation
  a_coef_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KIND_COEF) |=> in_ready_i)
    else $error("input blocked after coefficient transfer");

  // A new result only comes out of a computation, never straight from idle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a computation");

endmodule

bind fir_filter_direct_form fir_checker u_fir_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_filtered_i (out_o.filtered)
);
